### src/tsgt_pkg.sv
// Shared types and status codes for the TCP sequence gap tracker.
package tsgt_pkg;

    typedef enum logic [2:0] {
        ST_NEW_FLOW = 3'd0,
        ST_IN_ORDER = 3'd1,
        ST_STORED   = 3'd2,
        ST_OLD      = 3'd3,
        ST_ZERO_TIME = 3'd4,
        ST_NO_ROOM  = 3'd5
    } status_t;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_FLOW   = 9'b000000010,
        S_DECIDE = 9'b000000100,
        S_HSCAN  = 9'b000001000,
        S_PICK   = 9'b000010000,
        S_CLR    = 9'b000100000,
        S_CLOSE  = 9'b001000000,
        S_DONE   = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    localparam int DRAIN_MAX = 511;

endpackage

### src/tcp_sequence_gap_tracker.sv
// Top level of the TCP sequence gap tracker: flow table, held store and sequencer.
//
// Usage: segment descriptors enter on the in channel (in_valid/in_ready) with
// conn_key, seq_number, payload_bytes, fin_flag and arrival_time. One result per
// segment leaves on the out channel (out_valid/out_ready) with status,
// conn_closed, next_expected and drained_count.
// Timing: one segment at a time. The flow table is scanned entry by entry, each entry
// read through a register and then compared, and every pass over the held store works
// the same way. A segment that is held takes one pass. An in-order segment takes one
// search pass per released sequence plus a final search, one clearing pass per
// released sequence, and a closing pass on FIN.
// Every pass compares the stored entries one at a time through registered reads.
// in_ready is high only while the block is idle and its output register is free.
// Reset: all flow and held valid bits clear at once; no clearing pass.
// Stall: a result waits in the output register until out_ready; the next
// segment is taken once the result has been transferred.
module tcp_sequence_gap_tracker #(
    parameter int MAX_FLOWS  = 64,
    parameter int HELD_SLOTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] conn_key,
    input  logic [31:0] seq_number,
    input  logic [15:0] payload_bytes,
    input  logic        fin_flag,
    input  logic [31:0] arrival_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic        conn_closed,
    output logic [31:0] next_expected,
    output logic [8:0]  drained_count
);

    localparam int FW = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
    localparam int HW = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;

    // flow table
    logic [MAX_FLOWS-1:0] fvalid_reg;
    logic [63:0] fkey_mem [MAX_FLOWS];
    logic [31:0] fexp_mem [MAX_FLOWS];
    logic [31:0] ftime_mem [MAX_FLOWS];
    // held store
    logic [HELD_SLOTS-1:0] hvalid_reg;
    logic [FW-1:0] hflow_mem [HELD_SLOTS];
    logic [31:0] hseq_mem [HELD_SLOTS];
    logic [15:0] hsize_mem [HELD_SLOTS];
    logic        hfin_mem [HELD_SLOTS];
    logic [31:0] htime_mem [HELD_SLOTS];

    tsgt_pkg::state_t state_reg;
    logic [63:0] key_reg;
    logic [31:0] seq_reg, time_reg;
    logic [15:0] size_reg;
    logic        fin_reg;
    logic [FW:0] fidx_reg;
    logic [HW:0] hidx_reg;
    logic        found_reg, ffree_ok_reg, hfree_ok_reg, pick_ok_reg, closed_reg;
    logic [FW-1:0] flow_reg, ffree_reg;
    logic [HW-1:0] hfree_reg, pick_reg;
    logic [31:0] exp_reg, pickseq_reg, pickend_reg;
    logic        pickfin_reg;
    logic [31:0] picktime_reg;
    logic [8:0]  drained_reg;
    logic        ovalid_reg;
    logic [2:0]  ostatus_reg;
    logic        oclosed_reg;
    logic [31:0] oexp_reg;
    logic [8:0]  odrain_reg;

    // registered reads of the stored entries at the scan pointer (expected value at flow_reg)
    logic [63:0] rkey_reg;
    logic [31:0] rexp_reg;
    logic [FW-1:0] rhflow_reg;
    logic [31:0] rhseq_reg, rhtime_reg;
    logic [15:0] rhsize_reg;
    logic        rhfin_reg;

    logic [FW-1:0] fptr;
    logic [HW-1:0] hptr;
    assign fptr = fidx_reg[FW-1:0];
    assign hptr = hidx_reg[HW-1:0];

    assign in_ready = state_reg == tsgt_pkg::S_IDLE && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign status = ostatus_reg;
    assign conn_closed = oclosed_reg;
    assign next_expected = oexp_reg;
    assign drained_count = odrain_reg;

    logic f_last, h_last;
    assign f_last = fidx_reg == (FW+1)'(MAX_FLOWS - 1);
    assign h_last = hidx_reg == (HW+1)'(HELD_SLOTS - 1);

    logic hmatch;
    assign hmatch = hvalid_reg[hptr] && rhflow_reg == flow_reg;

    // memory read ports
    always_ff @(posedge clk)
    begin
        rkey_reg   <= fkey_mem[fptr];
        rexp_reg   <= fexp_mem[flow_reg];
        rhflow_reg <= hflow_mem[hptr];
        rhseq_reg  <= hseq_mem[hptr];
        rhsize_reg <= hsize_mem[hptr];
        rhfin_reg  <= hfin_mem[hptr];
        rhtime_reg <= htime_mem[hptr];
    end

    logic [31:0] newexp;
    assign newexp = seq_reg + 32'(size_reg) + 32'(fin_reg);

    // memory writes
    always_ff @(posedge clk)
    begin
        if (state_reg == tsgt_pkg::S_DECIDE && time_reg != 32'd0)
        begin
            if (!found_reg && ffree_ok_reg)
            begin
                fkey_mem[ffree_reg]  <= key_reg;
                fexp_mem[ffree_reg]  <= 32'd1;
                ftime_mem[ffree_reg] <= time_reg;
            end
            else if (found_reg && phase_reg && seq_reg == rexp_reg)
            begin
                fexp_mem[flow_reg]  <= newexp;
                ftime_mem[flow_reg] <= time_reg;
            end
        end
        // the last slot may be the only free one
        if (state_reg == tsgt_pkg::S_HSCAN && h_last && phase_reg && !found_reg
            && (hfree_ok_reg || !hvalid_reg[hptr]))
        begin
            hflow_mem[hfree_ok_reg ? hfree_reg : hptr] <= flow_reg;
            hseq_mem[hfree_ok_reg ? hfree_reg : hptr]  <= seq_reg;
            hsize_mem[hfree_ok_reg ? hfree_reg : hptr] <= size_reg;
            hfin_mem[hfree_ok_reg ? hfree_reg : hptr]  <= fin_reg;
            htime_mem[hfree_ok_reg ? hfree_reg : hptr] <= time_reg;
        end
        if (state_reg == tsgt_pkg::S_PICK && pick_ok_reg && pickseq_reg == exp_reg)
        begin
            fexp_mem[flow_reg]  <= pickend_reg;
            ftime_mem[flow_reg] <= picktime_reg;
        end
    end

    // sequencer
    // found_reg doubles as "in-order drain mode" during held scans
    logic phase_reg;  // selects the read half or the compare half of every scan step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tsgt_pkg::S_IDLE;
            fvalid_reg  <= '0;
            hvalid_reg  <= '0;
            ovalid_reg  <= 1'b0;
            phase_reg   <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                tsgt_pkg::S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        key_reg      <= conn_key;
                        seq_reg      <= seq_number;
                        size_reg     <= payload_bytes;
                        fin_reg      <= fin_flag;
                        time_reg     <= arrival_time;
                        fidx_reg     <= '0;
                        found_reg    <= 1'b0;
                        ffree_ok_reg <= 1'b0;
                        phase_reg    <= 1'b0;
                        state_reg    <= tsgt_pkg::S_FLOW;
                    end
                end
                tsgt_pkg::S_FLOW:
                begin
                    // read key, then compare on the next cycle
                    if (!phase_reg)
                        phase_reg <= 1'b1;
                    else
                    begin
                        phase_reg <= 1'b0;
                        if (fvalid_reg[fptr] && !found_reg && rkey_reg == key_reg)
                        begin
                            found_reg <= 1'b1;
                            flow_reg  <= fptr;
                        end
                        if (!fvalid_reg[fptr] && !ffree_ok_reg)
                        begin
                            ffree_ok_reg <= 1'b1;
                            ffree_reg    <= fptr;
                        end
                        if (f_last)
                            state_reg <= tsgt_pkg::S_DECIDE;
                        fidx_reg <= fidx_reg + 1'b1;
                    end
                end
                tsgt_pkg::S_DECIDE:
                begin
                    // flow_reg valid when found; fetch its expected value first
                    if (!phase_reg && found_reg)
                        phase_reg <= 1'b1;
                    else
                    begin
                        phase_reg   <= 1'b0;
                        closed_reg  <= 1'b0;
                        drained_reg <= '0;
                        hidx_reg    <= '0;
                        pick_ok_reg <= 1'b0;
                        hfree_ok_reg <= 1'b0;
                        ostatus_reg <= tsgt_pkg::ST_OLD;
                        exp_reg     <= found_reg ? rexp_reg : 32'd0;
                        if (time_reg == 32'd0)
                        begin
                            ostatus_reg <= tsgt_pkg::ST_ZERO_TIME;
                            state_reg   <= tsgt_pkg::S_DONE;
                        end
                        else if (!found_reg)
                        begin
                            state_reg <= tsgt_pkg::S_DONE;
                            if (ffree_ok_reg)
                            begin
                                fvalid_reg[ffree_reg] <= 1'b1;
                                ostatus_reg <= tsgt_pkg::ST_NEW_FLOW;
                                exp_reg     <= 32'd1;
                            end
                            else
                                ostatus_reg <= tsgt_pkg::ST_NO_ROOM;
                        end
                        else if (seq_reg == rexp_reg)
                        begin
                            ostatus_reg <= tsgt_pkg::ST_IN_ORDER;
                            exp_reg     <= newexp;
                            closed_reg  <= fin_reg;
                            state_reg   <= tsgt_pkg::S_HSCAN;
                        end
                        else if (seq_reg > rexp_reg)
                        begin
                            found_reg <= 1'b0;  // store mode
                            state_reg <= tsgt_pkg::S_HSCAN;
                        end
                        else
                            state_reg <= tsgt_pkg::S_DONE;
                    end
                end
                tsgt_pkg::S_HSCAN:
                begin
                    // drain mode: find lowest seq of flow; store mode: find free slot
                    if (!phase_reg)
                        phase_reg <= 1'b1;
                    else
                    begin
                        phase_reg <= 1'b0;
                        if (found_reg)
                        begin
                            if (hmatch && (!pick_ok_reg || rhseq_reg < pickseq_reg))
                            begin
                                pick_ok_reg  <= 1'b1;
                                pickseq_reg  <= rhseq_reg;
                                pickend_reg  <= rhseq_reg + 32'(rhsize_reg)
                                                + 32'(rhfin_reg);
                                pickfin_reg  <= rhfin_reg;
                                picktime_reg <= rhtime_reg;
                            end
                        end
                        else if (!hvalid_reg[hptr] && !hfree_ok_reg)
                        begin
                            hfree_ok_reg <= 1'b1;
                            hfree_reg    <= hptr;
                        end
                        hidx_reg <= hidx_reg + 1'b1;
                        if (h_last)
                            state_reg <= found_reg ? tsgt_pkg::S_PICK : tsgt_pkg::S_DONE;
                    end
                    if (!found_reg && h_last && phase_reg)
                    begin
                        if (hfree_ok_reg)
                        begin
                            hvalid_reg[hfree_reg] <= 1'b1;
                            ostatus_reg <= tsgt_pkg::ST_STORED;
                        end
                        else if (!hvalid_reg[hptr])
                        begin
                            hvalid_reg[hptr] <= 1'b1;
                            ostatus_reg <= tsgt_pkg::ST_STORED;
                        end
                        else
                            ostatus_reg <= tsgt_pkg::ST_NO_ROOM;
                    end
                end
                tsgt_pkg::S_PICK:
                begin
                    hidx_reg <= '0;
                    if (pick_ok_reg && pickseq_reg == exp_reg)
                    begin
                        exp_reg <= pickend_reg;
                        if (pickfin_reg)
                            closed_reg <= 1'b1;
                        state_reg <= tsgt_pkg::S_CLR;
                    end
                    else
                        state_reg <= closed_reg ? tsgt_pkg::S_CLOSE : tsgt_pkg::S_DONE;
                end
                tsgt_pkg::S_CLR:
                begin
                    // drop every held copy at the released sequence
                    if (!phase_reg)
                        phase_reg <= 1'b1;
                    else
                    begin
                        phase_reg <= 1'b0;
                        if (hmatch && rhseq_reg == pickseq_reg)
                        begin
                            hvalid_reg[hptr] <= 1'b0;
                            if (drained_reg != 9'(tsgt_pkg::DRAIN_MAX))
                                drained_reg <= drained_reg + 1'b1;
                        end
                        if (h_last)
                        begin
                            hidx_reg    <= '0;
                            pick_ok_reg <= 1'b0;
                            state_reg   <= tsgt_pkg::S_HSCAN;
                        end
                        else
                            hidx_reg <= hidx_reg + 1'b1;
                    end
                end
                tsgt_pkg::S_CLOSE:
                begin
                    if (!phase_reg)
                        phase_reg <= 1'b1;
                    else
                    begin
                        phase_reg <= 1'b0;
                        fvalid_reg[flow_reg] <= 1'b0;
                        if (hmatch)
                            hvalid_reg[hptr] <= 1'b0;
                        hidx_reg <= hidx_reg + 1'b1;
                        if (h_last)
                            state_reg <= tsgt_pkg::S_DONE;
                    end
                end
                tsgt_pkg::S_DONE:
                begin
                    state_reg <= tsgt_pkg::S_OUT;
                end
                tsgt_pkg::S_OUT:
                begin
                    if (!ovalid_reg)
                    begin
                        ovalid_reg  <= 1'b1;
                        oclosed_reg <= closed_reg && ostatus_reg == tsgt_pkg::ST_IN_ORDER;
                        oexp_reg    <= exp_reg;
                        odrain_reg  <= (ostatus_reg == tsgt_pkg::ST_IN_ORDER)
                                       ? drained_reg : 9'd0;
                        state_reg   <= tsgt_pkg::S_IDLE;
                    end
                end
                default:
                    state_reg <= tsgt_pkg::S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == tsgt_pkg::S_IDLE)
        else $error("ready outside idle");
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg) == tsgt_pkg::S_OUT)
        else $error("result without sequencer");
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_drain_only_inorder: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != tsgt_pkg::ST_IN_ORDER |-> drained_count == 9'd0
        && !conn_closed)
        else $error("drain on non in-order result");
`endif

endmodule
